// ===== sv/assert_macros.svh =====
// Assertion macros shared by the Sobel edge stream RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SOBEL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define SOBEL_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== sv/sobel_pkg.sv =====
// Shared constants, codes and stage types of the Sobel edge stream.
`default_nettype none
package sobel_pkg;

	// Frame geometry limits.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Field and register widths.
	localparam int PIX_W     = 8;
	localparam int RAM_W     = 2 * PIX_W;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int MODE_W    = 2;
	localparam int SUM_W     = PIX_W + 2;
	localparam int MAG_W     = SUM_W;
	localparam int SQ_W      = 2 * MAG_W + 1;
	localparam int THR_SQ_W  = 2 * CFG_W;

	// Register reset values.
	localparam int RESET_WIDTH     = 512;
	localparam int RESET_HEIGHT    = 512;
	localparam int RESET_THRESHOLD = 128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_MODE,
		REG_THRESHOLD
	} cfg_reg_t;

	typedef enum logic {
		CMD_PIXEL,
		CMD_FLUSH
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_VERT,
		MODE_HORZ,
		MODE_SUM,
		MODE_BINARY
	} mode_t;

	// Source of a result value.
	typedef enum logic [1:0] {
		SEL_LAST_MID,
		SEL_CENTER,
		SEL_SOBEL,
		SEL_RAM
	} sel_t;

	// Control handed from the scan controller to the kernel pipeline.
	typedef struct packed {
		logic             valid;
		logic             write;
		logic             cap_last;
		logic             frame_last;
		sel_t             sel;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] pixel;
	} s1_ctl_t;

endpackage
`default_nettype wire

// ===== sv/sobel_edge_stream_top.sv =====
// Sobel edge stream: takes one 8-bit grey pixel beat per clock in raster order and
// returns one result beat per pixel, also in raster order. A pixel's result leaves
// when the pixel one row and one column later is accepted; after the frame's last
// pixel, width+1 flush beats (tuser = 1) drain the rest, the final one with tlast.
// Border pixels pass unchanged; interior pixels get the gradient selected by mode.
// The block sustains one beat per clock while no output beat is stalled: the line
// stores are one 1024 x 16 RAM with one read and one write each cycle, which sets
// that rate. A result moves from the stage-1 register of the beat that releases it
// through the s2 and s3 registers into the output register. The whole pipeline holds
// while an output beat waits on m_tready. Pixels during drain and flushes during
// receive are consumed without a result. The RAM needs no clearing pass after reset.
`default_nettype none
module sobel_edge_stream_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [sobel_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
	input  wire logic                              s_tuser,   // [0] command
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [sobel_pkg::PIX_W-1:0]       m_tdata,   // [7:0] value
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sobel_pkg::CFG_W-1:0]       cfg_data
);
	import sobel_pkg::*;

	logic             advance, accept;
	logic             rd_en, wr_en;
	logic [COL_W-1:0] rd_addr, wr_addr;
	logic [RAM_W-1:0] rd_data, wr_data;
	s1_ctl_t          s1_q;

	// Pipeline moves unless a result beat is stuck at the output.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && advance;

	sobel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.accept    (accept),
		.command   (s_tuser),
		.pixel     (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.s1_q      (s1_q)
	);

	// Both line stores share one word per column.
	sobel_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sobel_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.s1_q      (s1_q),
		.rd_data   (rd_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.out_valid (m_tvalid),
		.out_value (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== sv/sobel_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module sobel_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/sobel_ctrl.sv =====
// Raster scan controller: column/row counters, drain sequencing, line store reads.
`default_nettype none
`include "assert_macros.svh"
module sobel_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic                          accept,
	input  wire logic                          command,
	input  wire logic [sobel_pkg::PIX_W-1:0]   pixel,
	input  wire logic                          cfg_we,
	input  wire logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sobel_pkg::CFG_W-1:0]   cfg_data,
	output logic                               rd_en,
	output logic      [sobel_pkg::COL_W-1:0]   rd_addr,
	output sobel_pkg::s1_ctl_t                 s1_q
);
	import sobel_pkg::*;

	logic [COL_W-1:0] w_last_q;
	logic [ROW_W-1:0] h_last_q;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic             drain_q, drain_d;
	logic             first_q, first_d;
	logic             restart;
	s1_ctl_t          s1_d;

	// Clamp a written width to the supported range, kept as last column index.
	function automatic logic [COL_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
		if (v < CFG_W'(3)) begin
			return COL_W'(2);
		end else if (v > CFG_W'(MAX_WIDTH)) begin
			return COL_W'(MAX_WIDTH - 1);
		end
		return COL_W'(v - CFG_W'(1));
	endfunction

	// Clamp a written height, kept as last row index.
	function automatic logic [ROW_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
		if (v < CFG_W'(3)) begin
			return ROW_W'(2);
		end else if (v > CFG_W'(MAX_HEIGHT)) begin
			return ROW_W'(MAX_HEIGHT - 1);
		end
		return ROW_W'(v - CFG_W'(1));
	endfunction

	// A geometry write restarts the frame.
	assign restart = cfg_we && (cfg_reg_t'(cfg_index) == REG_WIDTH ||
		cfg_reg_t'(cfg_index) == REG_HEIGHT);

	assign rd_addr = col_q;

	// Decode the accepted beat against the scan position.
	always_comb begin
		rd_en        = 1'b0;
		s1_d         = '0;
		s1_d.sel     = SEL_SOBEL;
		s1_d.addr    = col_q;
		s1_d.pixel   = pixel;
		col_d        = col_q;
		row_d        = row_q;
		drain_d      = drain_q;
		first_d      = first_q;
		if (accept) begin
			if (cmd_t'(command) == CMD_PIXEL && !drain_q) begin
				rd_en         = 1'b1;
				s1_d.write    = 1'b1;
				s1_d.cap_last = (col_q == w_last_q);
				s1_d.valid    = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
				if (col_q == '0) begin
					s1_d.sel = SEL_LAST_MID;
				end else if (row_q == ROW_W'(1) || col_q == COL_W'(1)) begin
					s1_d.sel = SEL_CENTER;
				end
				if (col_q == w_last_q) begin
					col_d = '0;
					if (row_q == h_last_q) begin
						drain_d = 1'b1;
						first_d = 1'b1;
					end else begin
						row_d = row_q + ROW_W'(1);
					end
				end else begin
					col_d = col_q + COL_W'(1);
				end
			end else if (cmd_t'(command) == CMD_FLUSH && drain_q) begin
				s1_d.valid = 1'b1;
				if (first_q) begin
					// Last pixel of the second to last row comes from the held copy.
					s1_d.sel = SEL_LAST_MID;
					first_d  = 1'b0;
				end else begin
					rd_en    = 1'b1;
					s1_d.sel = SEL_RAM;
					if (col_q == w_last_q) begin
						s1_d.frame_last = 1'b1;
						col_d           = '0;
						row_d           = '0;
						drain_d         = 1'b0;
					end else begin
						col_d = col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// Geometry, scan counters and the stage-1 control register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= COL_W'(RESET_WIDTH - 1);
			h_last_q <= ROW_W'(RESET_HEIGHT - 1);
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= 1'b0;
			first_q  <= 1'b0;
			s1_q     <= '0;
		end else begin
			if (cfg_we && cfg_reg_t'(cfg_index) == REG_WIDTH) begin
				w_last_q <= clamp_w(cfg_data);
			end
			if (cfg_we && cfg_reg_t'(cfg_index) == REG_HEIGHT) begin
				h_last_q <= clamp_h(cfg_data);
			end
			if (restart) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= 1'b0;
				first_q <= 1'b0;
			end else begin
				col_q   <= col_d;
				row_q   <= row_d;
				drain_q <= drain_d;
				first_q <= first_d;
			end
			if (advance) begin
				s1_q <= s1_d;
			end
		end
	end

	`SOBEL_ASSERT(a_col_in_row, clk, arst_n, col_q <= w_last_q, "column counter past row end")
	`SOBEL_ASSERT(a_row_in_frame, clk, arst_n, row_q <= h_last_q, "row counter past frame end")
	`SOBEL_ASSERT(a_first_drain, clk, arst_n, first_q |-> (drain_q && col_q == '0),
		"drain start flag outside drain")

endmodule
`default_nettype wire

// ===== sv/sobel_kernel.sv =====
// Window, gradient and mode pipeline with the output register.
`default_nettype none
`include "assert_macros.svh"
module sobel_kernel (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            advance,
	input  wire sobel_pkg::s1_ctl_t              s1_q,
	input  wire logic [sobel_pkg::RAM_W-1:0]     rd_data,
	input  wire logic                            cfg_we,
	input  wire logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sobel_pkg::CFG_W-1:0]     cfg_data,
	output logic                                 wr_en,
	output logic      [sobel_pkg::COL_W-1:0]     wr_addr,
	output logic      [sobel_pkg::RAM_W-1:0]     wr_data,
	output logic                                 out_valid,
	output logic      [sobel_pkg::PIX_W-1:0]     out_value,
	output logic                                 out_last
);
	import sobel_pkg::*;

	mode_t              mode_q;
	logic [CFG_W-1:0]    thr_q;
	logic [THR_SQ_W-1:0] thr_sq_q;

	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] nw    [3][3];
	logic [PIX_W-1:0] last_mid_q;
	logic [PIX_W-1:0] top, mid, pass_v;
	logic [SUM_W-1:0] sum_t, sum_b, sum_l, sum_r;
	logic signed [SUM_W:0] dy, dx;
	logic [MAG_W-1:0] gy, gx;

	logic             v_s2, last_s2, sobel_s2;
	logic [PIX_W-1:0] pass_s2;
	logic [MAG_W-1:0] gx_s2, gy_s2;

	logic [2*MAG_W-1:0] gx2, gy2;
	logic [SQ_W-1:0]    sq_sum;
	logic [MAG_W:0]     abs_sum;
	logic [PIX_W-1:0]   lin;

	logic             v_s3, last_s3, sobel_s3;
	logic [PIX_W-1:0] pass_s3, lin_s3;
	logic [SQ_W-1:0]  sq_s3;
	logic [PIX_W-1:0] result;

	logic             out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_value_q;

	// Saturate a magnitude to the pixel range.
	function automatic logic [PIX_W-1:0] sat(input logic [MAG_W:0] v);
		if (v > (MAG_W+1)'(2**PIX_W - 1)) begin
			return {PIX_W{1'b1}};
		end
		return v[PIX_W-1:0];
	endfunction

	// Mode and threshold registers; the squared threshold follows in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SUM;
			thr_q    <= CFG_W'(RESET_THRESHOLD);
			thr_sq_q <= THR_SQ_W'(RESET_THRESHOLD * RESET_THRESHOLD);
		end else begin
			if (cfg_we && cfg_reg_t'(cfg_index) == REG_MODE) begin
				mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
			end
			if (cfg_we && cfg_reg_t'(cfg_index) == REG_THRESHOLD) begin
				thr_q <= cfg_data;
			end
			thr_sq_q <= THR_SQ_W'(thr_q) * THR_SQ_W'(thr_q);
		end
	end

	// Line store word holds the row above in the high byte, two rows above low.
	assign top = rd_data[PIX_W-1:0];
	assign mid = rd_data[RAM_W-1:PIX_W];

	// Write back: the row above moves down, the new pixel becomes the row above.
	assign wr_en   = advance && s1_q.write;
	assign wr_addr = s1_q.addr;
	assign wr_data = {s1_q.pixel, mid};

	// Window after the shift by one column.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][1];
			nw[i][1] = win_q[i][2];
		end
		nw[0][2] = top;
		nw[1][2] = mid;
		nw[2][2] = s1_q.pixel;
	end

	// Gradients over the shifted window, weights 1,2,1.
	always_comb begin
		sum_t = SUM_W'(nw[0][0]) + {1'b0, nw[0][1], 1'b0} + SUM_W'(nw[0][2]);
		sum_b = SUM_W'(nw[2][0]) + {1'b0, nw[2][1], 1'b0} + SUM_W'(nw[2][2]);
		sum_l = SUM_W'(nw[0][0]) + {1'b0, nw[1][0], 1'b0} + SUM_W'(nw[2][0]);
		sum_r = SUM_W'(nw[0][2]) + {1'b0, nw[1][2], 1'b0} + SUM_W'(nw[2][2]);
		dy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
		dx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy    = dy[SUM_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
		gx    = dx[SUM_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
	end

	// Value of border pixels and drained results.
	always_comb begin
		case (s1_q.sel)
			SEL_LAST_MID: pass_v = last_mid_q;
			SEL_CENTER:   pass_v = win_q[1][2];
			SEL_RAM:      pass_v = mid;
			default:      pass_v = '0;
		endcase
	end

	// Squares, abs sum and the saturated modes.
	always_comb begin
		gx2     = (2*MAG_W)'(gx_s2) * (2*MAG_W)'(gx_s2);
		gy2     = (2*MAG_W)'(gy_s2) * (2*MAG_W)'(gy_s2);
		sq_sum  = SQ_W'(gx2) + SQ_W'(gy2);
		abs_sum = (MAG_W+1)'(gx_s2) + (MAG_W+1)'(gy_s2);
		case (mode_q)
			MODE_VERT: lin = sat((MAG_W+1)'(gy_s2));
			MODE_HORZ: lin = sat((MAG_W+1)'(gx_s2));
			default:   lin = sat(abs_sum);
		endcase
	end

	// Final selection, binary mode compares squared magnitudes.
	always_comb begin
		if (!sobel_s3) begin
			result = pass_s3;
		end else if (mode_q == MODE_BINARY) begin
			result = (THR_SQ_W'(sq_s3) >= thr_sq_q) ? {PIX_W{1'b1}} : '0;
		end else begin
			result = lin_s3;
		end
	end

	// Payload pipeline registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (s1_q.write) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						win_q[i][j] <= nw[i][j];
					end
				end
			end
			if (s1_q.cap_last) begin
				last_mid_q <= mid;
			end
			pass_s2     <= pass_v;
			gx_s2       <= gx;
			gy_s2       <= gy;
			pass_s3     <= pass_s2;
			lin_s3      <= lin;
			sq_s3       <= sq_sum;
			out_value_q <= result;
		end
	end

	// Stage valid bits and the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			sobel_s2    <= 1'b0;
			v_s3        <= 1'b0;
			last_s3     <= 1'b0;
			sobel_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (advance) begin
			v_s2        <= s1_q.valid;
			last_s2     <= s1_q.frame_last;
			sobel_s2    <= (s1_q.sel == SEL_SOBEL);
			v_s3        <= v_s2;
			last_s3     <= last_s2;
			sobel_s3    <= sobel_s2;
			out_valid_q <= v_s3;
			out_last_q  <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

	`SOBEL_NEVER(a_last_is_border, clk, arst_n, v_s3 && last_s3 && sobel_s3,
		"frame end marked on an interior pixel")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Sobel edge stream block.
`timescale 1ns / 1ps

module testbench;
	import sobel_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_BEATS  = 150;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             frame_last;
	} edge_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [PIX_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Register mirror and scan state of the edge predictor.
	logic [CFG_W-1:0] cur_width;
	logic [CFG_W-1:0] cur_height;
	mode_t            cur_mode;
	logic [CFG_W-1:0] cur_threshold;
	logic [PIX_W-1:0] one_row_up [MAX_WIDTH];
	logic [PIX_W-1:0] two_rows_up [MAX_WIDTH];
	logic [PIX_W-1:0] kernel_win [3][3];
	int unsigned      pix_col;
	int unsigned      pix_row;
	int unsigned      out_pos;

	edge_result_t expected_q[$];

	int s_idle_max;
	int r_idle_max;
	int hold_request;
	int fail_count;
	int results_checked;
	int frames_seen;
	int beats_sent;
	int useful_beats;
	int cycles;

	sobel_edge_stream_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] pixel
		.s_tuser   (s_tuser),   // [0] command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] value
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a correct run ends long before this count.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] clip_byte(int v);
		return (v > 255) ? 8'hFF : v[PIX_W-1:0];
	endfunction

	function automatic void restart_scan();
		pix_col = 0;
		pix_row = 0;
		out_pos = 0;
	endfunction

	function automatic int draw_gap(int max_gap);
		return (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return 3;
			default: return 15;
		endcase
	endfunction

	// Gradient of the current 3x3 window under the selected mode.
	function automatic logic [PIX_W-1:0] kernel_result();
		int top_sum, bot_sum, left_sum, right_sum, gx, gy, thr;
		top_sum   = kernel_win[0][0] + 2 * kernel_win[0][1] + kernel_win[0][2];
		bot_sum   = kernel_win[2][0] + 2 * kernel_win[2][1] + kernel_win[2][2];
		left_sum  = kernel_win[0][0] + 2 * kernel_win[1][0] + kernel_win[2][0];
		right_sum = kernel_win[0][2] + 2 * kernel_win[1][2] + kernel_win[2][2];
		gy = bot_sum - top_sum;
		gx = right_sum - left_sum;
		if (gy < 0)
			gy = -gy;
		if (gx < 0)
			gx = -gx;
		thr = cur_threshold;
		case (cur_mode)
			MODE_VERT: return clip_byte(gy);
			MODE_HORZ: return clip_byte(gx);
			MODE_SUM:  return clip_byte(gx + gy);
			default:   return (gx * gx + gy * gy >= thr * thr) ? 8'hFF : 8'h00;
		endcase
	endfunction

	// Advance the predicted scan by one accepted beat and queue any result it causes.
	task automatic predict_beat(cmd_t cmd, logic [PIX_W-1:0] px);
		int unsigned w, h, c, r, k;
		logic [PIX_W-1:0] prev_end;
		edge_result_t res;
		w = clamp_dim(cur_width, MAX_WIDTH);
		h = clamp_dim(cur_height, MAX_HEIGHT);
		if (cmd == CMD_FLUSH) begin
			// Drain the tail; a flush during the receive phase does nothing.
			if (pix_row < h)
				return;
			r = out_pos / w;
			c = out_pos % w;
			res.value = (r + 2 == h) ? two_rows_up[c] : one_row_up[c];
			out_pos++;
			res.frame_last = (out_pos >= w * h);
			if (res.frame_last)
				restart_scan();
			expected_q.push_back(res);
			return;
		end
		// A pixel during the drain phase is dropped.
		if (pix_row >= h)
			return;
		c = pix_col;
		k = pix_row * w + pix_col;
		prev_end = two_rows_up[w - 1];
		for (int i = 0; i < 3; i++) begin
			kernel_win[i][0] = kernel_win[i][1];
			kernel_win[i][1] = kernel_win[i][2];
		end
		kernel_win[0][2] = two_rows_up[c];
		kernel_win[1][2] = one_row_up[c];
		kernel_win[2][2] = px;
		two_rows_up[c] = one_row_up[c];
		one_row_up[c] = px;
		if (k >= w + 1) begin
			if (pix_col == 0)
				res.value = prev_end;
			else if (pix_row == 1 || pix_col == 1)
				res.value = kernel_win[1][1];
			else
				res.value = kernel_result();
			res.frame_last = 1'b0;
			out_pos++;
			expected_q.push_back(res);
		end
		pix_col++;
		if (pix_col >= w) begin
			pix_col = 0;
			pix_row++;
		end
	endtask

	// Offer one input beat after a random gap and wait until the block takes it.
	task automatic push_beat(cmd_t cmd, logic [PIX_W-1:0] px);
		int gap;
		gap = draw_gap(s_idle_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
		predict_beat(cmd, px);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_WIDTH: begin
				cur_width = val;
				restart_scan();
			end
			REG_HEIGHT: begin
				cur_height = val;
				restart_scan();
			end
			REG_MODE:      cur_mode = mode_t'(val[MODE_W-1:0]);
			REG_THRESHOLD: cur_threshold = val;
			default:       ;
		endcase
	endtask

	// Write all registers once the block has gone quiet.
	task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, mode_t m,
			logic [CFG_W-1:0] thr);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_MODE, CFG_W'(m));
		write_reg(REG_THRESHOLD, thr);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] frame_pixel(int style, int unsigned r,
			int unsigned c);
		case (style)
			0: return PIX_W'($urandom_range(255, 0));
			1: return $urandom_range(1, 0) ? 8'hFF : 8'h00;
			2: return PIX_W'(c * 29 + r * 13 + $urandom_range(15, 0));
			default: return ((r + c) % 4 < 2) ? 8'd250 : 8'd4;
		endcase
	endfunction

	// Send one frame in the current geometry, then its drain flushes. Stray beats
	// are mixed in at the given percentage; a non-negative cut aborts the frame.
	task automatic run_frame(int style, int noise_pct, int cut);
		int unsigned w, h;
		int n;
		w = clamp_dim(cur_width, MAX_WIDTH);
		h = clamp_dim(cur_height, MAX_HEIGHT);
		n = 0;
		for (int unsigned r = 0; r < h; r++) begin
			for (int unsigned c = 0; c < w; c++) begin
				if (n == cut)
					return;
				if ($urandom_range(99, 0) < noise_pct)
					push_beat(CMD_FLUSH, PIX_W'($urandom));
				push_beat(CMD_PIXEL, frame_pixel(style, r, c));
				n++;
				useful_beats++;
			end
		end
		for (int unsigned i = 0; i <= w; i++) begin
			if (n == cut)
				return;
			if ($urandom_range(99, 0) < noise_pct)
				push_beat(CMD_PIXEL, PIX_W'($urandom));
			push_beat(CMD_FLUSH, PIX_W'($urandom));
			n++;
			useful_beats++;
		end
	endtask

	// A partial frame in the reset geometry and mode: only pass-through results.
	task automatic test_reset_state();
		s_idle_max = 0;
		r_idle_max = 3;
		for (int i = 0; i < 520; i++)
			push_beat(CMD_PIXEL, PIX_W'($urandom));
	endtask

	// Smallest frame with extreme pixels, a stray flush and a stray pixel.
	task automatic test_directed_frame();
		logic [PIX_W-1:0] pix [9];
		pix = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		configure(11'd3, 11'd3, MODE_VERT, 11'd128);
		s_idle_max = 3;
		r_idle_max = 3;
		for (int i = 0; i < 9; i++) begin
			push_beat(CMD_PIXEL, pix[i]);
			if (i == 1)
				push_beat(CMD_FLUSH, 8'hFF);
		end
		push_beat(CMD_FLUSH, 8'h00);
		push_beat(CMD_PIXEL, 8'hFF);
		for (int i = 0; i < 3; i++)
			push_beat(CMD_FLUSH, 8'h00);
	endtask

	// Every mode once, then the binary mode across its threshold range.
	task automatic test_each_mode();
		logic [CFG_W-1:0] thr [4];
		thr = '{11'd0, 11'd200, 11'd1442, 11'd2047};
		s_idle_max = 15;
		r_idle_max = 15;
		for (int m = 0; m < 4; m++) begin
			configure(11'd5, 11'd4, mode_t'(m), 11'd100);
			run_frame(m % 2, 0, -1);
		end
		foreach (thr[i]) begin
			configure(11'd4, 11'd4, MODE_BINARY, thr[i]);
			run_frame(1, 0, -1);
		end
	endtask

	// Clamped geometry at both ends, and frames cut short by a register write.
	task automatic test_geometry_limits();
		s_idle_max = 0;
		r_idle_max = 0;
		configure(11'd0, 11'd5, MODE_SUM, 11'd128);
		run_frame(0, 0, -1);
		configure(11'd2047, 11'd1, MODE_BINARY, 11'd300);
		run_frame(2, 0, 1030);
		s_idle_max = 3;
		r_idle_max = 3;
		configure(11'd1, 11'd2, MODE_HORZ, 11'd50);
		run_frame(0, 0, -1);
		configure(11'd6, 11'd5, MODE_SUM, 11'd128);
		run_frame(0, 0, 17);
		configure(11'd5, 11'd3, MODE_VERT, 11'd128);
		run_frame(3, 0, 17);
		configure(11'd7, 11'd4, MODE_VERT, 11'd128);
		run_frame(3, 0, -1);
	endtask

	// Long output hold while the sender keeps offering pixels.
	task automatic test_backpressure();
		configure(11'd10, 11'd6, MODE_SUM, 11'd128);
		s_idle_max = 0;
		r_idle_max = 0;
		hold_request = HOLD_CYCLES;
		run_frame(0, 0, -1);
	endtask

	// Random geometry, mode and content; a few frames are aborted part way.
	task automatic test_random_frames();
		int target, pick, cut;
		logic [CFG_W-1:0] wr, hr, thr;
		target = useful_beats + RANDOM_BEATS;
		while (useful_beats < target) begin
			pick = $urandom_range(99, 0);
			wr = (pick < 85) ? CFG_W'($urandom_range(14, 3)) :
				(pick < 90) ? CFG_W'($urandom_range(2, 0)) : CFG_W'($urandom_range(40, 15));
			pick = $urandom_range(99, 0);
			hr = (pick < 85) ? CFG_W'($urandom_range(8, 3)) :
				(pick < 90) ? CFG_W'($urandom_range(2, 0)) : CFG_W'($urandom_range(16, 9));
			pick = $urandom_range(3, 0);
			thr = (pick == 0) ? CFG_W'($urandom_range(2047, 0)) :
				CFG_W'($urandom_range(400, 0));
			configure(wr, hr, mode_t'($urandom_range(3, 0)), thr);
			s_idle_max = pick_idle();
			r_idle_max = pick_idle();
			cut = -1;
			if ($urandom_range(9, 0) == 0)
				cut = $urandom_range(clamp_dim(wr, MAX_WIDTH) * (clamp_dim(hr, MAX_HEIGHT) + 1), 0);
			run_frame($urandom_range(3, 0), ($urandom_range(3, 0) == 0) ? 8 : 0, cut);
		end
	endtask

	// Result sink: random stalls, plus a long hold on request.
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				gap = hold_request;
				hold_request = 0;
			end else begin
				gap = draw_gap(r_idle_max);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid && hold_request == 0)
				@(posedge clk);
		end
	end

	// Compare each result beat with the oldest predicted result.
	always @(posedge clk) begin
		edge_result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("result beat with none expected: value %0d, tlast %0b",
					m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				results_checked++;
				if (want.frame_last)
					frames_seen++;
				if (m_tdata !== want.value) begin
					$error("value mismatch: expected %0d, actual %0d", want.value, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.frame_last) begin
					$error("frame_last mismatch: expected %0b, actual %0b",
						want.frame_last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		s_tuser       <= CMD_PIXEL;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_WIDTH;
		cfg_data      <= '0;
		arst_n        <= 1'b0;
		cur_width     = RESET_WIDTH;
		cur_height    = RESET_HEIGHT;
		cur_mode      = MODE_SUM;
		cur_threshold = RESET_THRESHOLD;
		foreach (one_row_up[i]) begin
			one_row_up[i]  = '0;
			two_rows_up[i] = '0;
		end
		kernel_win      = '{default: '0};
		restart_scan();
		s_idle_max      = 0;
		r_idle_max      = 0;
		hold_request    = 0;
		fail_count      = 0;
		results_checked = 0;
		frames_seen     = 0;
		beats_sent      = 0;
		useful_beats    = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_frame();
		test_each_mode();
		test_geometry_limits();
		test_backpressure();
		test_random_frames();

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("summary: %0d input beats accepted, %0d results checked, %0d frames closed",
			beats_sent, results_checked, frames_seen);
		$display("summary: all modes, clamped geometry, aborted frames, stray beats, %0d-cycle hold",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
